### src/telemetry_frame_decoder_assert.svh
// Assertion macros for the telemetry frame decoder checker.
// Depends on nothing; included by the checker file that holds the concurrent assertions.
`ifndef TELEMETRY_FRAME_DECODER_ASSERT_SVH
`define TELEMETRY_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tfd_pkg.sv
// Shared constants and the CRC-8 byte update for the telemetry frame decoder.
// No dependencies; used by the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package tfd_pkg;

    localparam int HEADER_BYTES     = 5;
    localparam int MAX_PAYLOAD_DEF  = 16;
    localparam int PAYLOAD_SLOTS    = 16;
    localparam logic [7:0] START_BYTE_RESET = 8'hFE;
    localparam logic [7:0] CRC_POLY         = 8'h07;

    // CRC-8/SMBus: MSB first, no reflection, no final xor.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### src/telemetry_frame_decoder.sv
// Telemetry frame decoder: start-byte hunt, header and payload capture, CRC-8 check.
// Depends on tfd_pkg.
//
// Channel   Dir  Handshake            Payload
// in        in   in_valid / in_stall  rx_byte
// out       out  out_valid / out_stall frame fields, payload_count, payload, crc_ok, crc
// cfg       in   cfg_we               cfg_wdata (start byte)
//
// One byte a cycle is accepted while in_stall is low; each request is handled in the cycle it is taken.
// The CRC byte's result is registered and shows on the outputs in the cycle after the byte is taken.
// Input stalls only when the CRC byte is next and a result still waits downstream.
// Reset (rst_n low, asynchronous) returns to hunting with start byte 0xFE.
`timescale 1ns / 1ps
`default_nettype none

module telemetry_frame_decoder #(
    parameter int MAX_PAYLOAD = tfd_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       source_addr,
    output logic [7:0]       node_addr,
    output logic [7:0]       channel_num,
    output logic [7:0]       param_num,
    output logic [7:0]       type_length,
    output logic [4:0]       payload_count,
    output logic [63:0]      payload_low,
    output logic [63:0]      payload_high,
    output logic             crc_ok,
    output logic [7:0]       computed_crc
);

    localparam int PIDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int HIDX_W = $clog2(tfd_pkg::HEADER_BYTES);
    localparam logic [4:0] MAX_LEN  = 5'(MAX_PAYLOAD);
    localparam logic [4:0] HDR_LEN  = 5'(tfd_pkg::HEADER_BYTES);

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_CRC     = 4'b1000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  byte_count_reg, byte_count_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  start_byte_reg;
    logic [7:0]  hdr_reg [tfd_pkg::HEADER_BYTES];
    logic [7:0]  pay_reg [MAX_PAYLOAD];

    logic        in_acc;
    logic        out_load;
    logic [4:0]  pay_len;
    logic [4:0]  pay_idx;
    logic [7:0]  crc_upd;
    logic [7:0]  pay_byte [tfd_pkg::PAYLOAD_SLOTS];
    logic [63:0] pay_low_next, pay_high_next;

    logic        out_valid_reg;
    logic [7:0]  src_reg, node_reg, chan_reg, param_reg, tl_reg, ccrc_reg;
    logic [4:0]  count_reg;
    logic [63:0] low_reg, high_reg;
    logic        ok_reg;

    // Hold the CRC byte only while its result slot is occupied and stalled.
    assign in_stall = out_valid_reg && out_stall && (phase_reg == PH_CRC);
    assign in_acc   = in_valid && !in_stall;
    assign out_load = in_acc && (phase_reg == PH_CRC);

    // Payload length is the low nibble of type/length plus one, saturated at MAX_PAYLOAD.
    always_comb
    begin
        pay_len = {1'b0, hdr_reg[tfd_pkg::HEADER_BYTES - 1][3:0]} + 5'd1;
        if (pay_len > MAX_LEN)
        begin
            pay_len = MAX_LEN;
        end
    end

    assign pay_idx = byte_count_reg - HDR_LEN;
    assign crc_upd = tfd_pkg::crc8_update(crc_reg, rx_byte);

    // Advance the frame phase on each accepted byte.
    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        if (in_acc)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == start_byte_reg)
                    begin
                        phase_next      = PH_HEADER;
                        byte_count_next = '0;
                        crc_next        = '0;
                    end
                end
                PH_HEADER:
                begin
                    crc_next        = crc_upd;
                    byte_count_next = byte_count_reg + 5'd1;
                    if (byte_count_next >= HDR_LEN)
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    crc_next        = crc_upd;
                    byte_count_next = byte_count_reg + 5'd1;
                    if ((byte_count_reg < HDR_LEN) || ((pay_idx + 5'd1) >= pay_len))
                    begin
                        phase_next = PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            byte_count_reg <= '0;
            crc_reg        <= '0;
            start_byte_reg <= tfd_pkg::START_BYTE_RESET;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            if (cfg_we)
            begin
                start_byte_reg <= cfg_wdata;
            end
        end
    end

    // Capture header and payload bytes; no reset, every read entry is written first.
    always_ff @(posedge clk)
    begin
        if (in_acc && (phase_reg == PH_HEADER) && (byte_count_reg < HDR_LEN))
        begin
            hdr_reg[byte_count_reg[HIDX_W-1:0]] <= rx_byte;
        end
        if (in_acc && (phase_reg == PH_PAYLOAD) && (byte_count_reg >= HDR_LEN)
            && (pay_idx < MAX_LEN))
        begin
            pay_reg[pay_idx[PIDX_W-1:0]] <= rx_byte;
        end
    end

    // Zero the payload slots at and above the frame length.
    for (genvar g = 0; g < tfd_pkg::PAYLOAD_SLOTS; g++)
    begin : g_pay
        if (g < MAX_PAYLOAD)
        begin : g_used
            assign pay_byte[g] = (5'(g) < pay_len) ? pay_reg[g] : 8'h00;
        end
        else
        begin : g_none
            assign pay_byte[g] = 8'h00;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            pay_low_next[8*i +: 8]  = pay_byte[i];
            pay_high_next[8*i +: 8] = pay_byte[i + 8];
        end
    end

    // Result register: load on the CRC byte, drop once taken downstream.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            src_reg   <= hdr_reg[0];
            node_reg  <= hdr_reg[1];
            chan_reg  <= hdr_reg[2];
            param_reg <= hdr_reg[3];
            tl_reg    <= hdr_reg[4];
            count_reg <= pay_len;
            low_reg   <= pay_low_next;
            high_reg  <= pay_high_next;
            ok_reg    <= (crc_reg == rx_byte);
            ccrc_reg  <= crc_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign source_addr   = src_reg;
    assign node_addr     = node_reg;
    assign channel_num   = chan_reg;
    assign param_num     = param_reg;
    assign type_length   = tl_reg;
    assign payload_count = count_reg;
    assign payload_low   = low_reg;
    assign payload_high  = high_reg;
    assign crc_ok        = ok_reg;
    assign computed_crc  = ccrc_reg;

endmodule

`default_nettype wire

### src/tfd_checker.sv
// Port-level assertions for the telemetry frame decoder, bound to the top level.
// Depends on tfd_pkg and telemetry_frame_decoder_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "telemetry_frame_decoder_assert.svh"

module tfd_port_assert (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [4:0]  payload_count,
    input wire logic [63:0] payload_high
);

    localparam logic [4:0] SLOTS = 5'(tfd_pkg::PAYLOAD_SLOTS);

    logic out_held;
    logic count_ok;
    logic short_frame;
    logic high_zero;

    assign out_held    = out_valid && out_stall;
    assign count_ok    = (payload_count != 5'd0) && (payload_count <= SLOTS);
    assign short_frame = out_valid && (payload_count <= 5'd8);
    assign high_zero   = (payload_high == 64'd0);

    `TFD_ASSERT_NXT(a_out_hold, clk, rst_n, out_held, out_valid, "result dropped")
    `TFD_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_held, "stall with no result")
    `TFD_ASSERT_IMP(a_count_range, clk, rst_n, out_valid, count_ok, "bad payload count")
    `TFD_ASSERT_IMP(a_high_zero, clk, rst_n, short_frame, high_zero, "upper payload not zero")

endmodule

bind telemetry_frame_decoder tfd_port_assert u_tfd_port_assert (.*);

`default_nettype wire

### tb/tfd_checker.sv
// Scoreboard for the telemetry frame decoder: follows the byte stream, predicts each decoded frame.
// Depends on tfd_pkg for the start byte reset value and header length; instantiated beside the block by the bench top.
`timescale 1ns / 1ps

module tfd_checker #(
    parameter int MAX_PAYLOAD = tfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  source_addr,
    input  logic [7:0]  node_addr,
    input  logic [7:0]  channel_num,
    input  logic [7:0]  param_num,
    input  logic [7:0]  type_length,
    input  logic [4:0]  payload_count,
    input  logic [63:0] payload_low,
    input  logic [63:0] payload_high,
    input  logic        crc_ok,
    input  logic [7:0]  computed_crc,
    output int          fail_count,
    output int          pending,
    output logic        hunting
);

    typedef enum logic [3:0] {
        SEEK_START  = 4'b0001,
        TAKE_HEADER = 4'b0010,
        TAKE_BODY   = 4'b0100,
        TAKE_CRC    = 4'b1000
    } rx_phase_t;

    typedef struct {
        logic [7:0]  source_addr;
        logic [7:0]  node_addr;
        logic [7:0]  channel_num;
        logic [7:0]  param_num;
        logic [7:0]  type_length;
        logic [4:0]  payload_count;
        logic [63:0] payload_low;
        logic [63:0] payload_high;
        logic        crc_ok;
        logic [7:0]  computed_crc;
    } frame_result_t;

    logic [7:0]    marker;
    rx_phase_t     phase;
    logic [4:0]    nbytes;
    logic [7:0]    hdr_mem [tfd_pkg::HEADER_BYTES];
    logic [7:0]    body_mem [16];
    logic [7:0]    crc_acc;
    frame_result_t frames_due [$];
    int            errs;

    // CRC-8/SMBus, one data bit at a time, MSB first.
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ data[i];
            c = {c[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
        end
        return c;
    endfunction

    function automatic int body_len();
        int n;
        n = int'(hdr_mem[4][3:0]) + 1;
        return (n > MAX_PAYLOAD) ? MAX_PAYLOAD : n;
    endfunction

    // Advance the decoder state by one accepted byte; queue a frame on the CRC byte.
    function void absorb(input logic [7:0] b);
        frame_result_t fr;
        int            n;
        unique case (phase)
            SEEK_START:
            begin
                if (b == marker)
                begin
                    phase   = TAKE_HEADER;
                    nbytes  = '0;
                    crc_acc = '0;
                end
            end
            TAKE_HEADER:
            begin
                hdr_mem[nbytes] = b;
                crc_acc = crc_step(crc_acc, b);
                nbytes  = nbytes + 5'd1;
                if (nbytes >= tfd_pkg::HEADER_BYTES)
                begin
                    phase = TAKE_BODY;
                end
            end
            TAKE_BODY:
            begin
                n = int'(nbytes) - tfd_pkg::HEADER_BYTES;
                body_mem[n] = b;
                crc_acc = crc_step(crc_acc, b);
                if (n + 1 >= body_len())
                begin
                    phase = TAKE_CRC;
                end
                nbytes = nbytes + 5'd1;
            end
            default:
            begin
                n = body_len();
                fr.payload_low  = '0;
                fr.payload_high = '0;
                for (int i = 0; i < n; i++)
                begin
                    if (i < 8)
                    begin
                        fr.payload_low[8*i +: 8] = body_mem[i];
                    end
                    else
                    begin
                        fr.payload_high[8*(i-8) +: 8] = body_mem[i];
                    end
                end
                fr.source_addr   = hdr_mem[0];
                fr.node_addr     = hdr_mem[1];
                fr.channel_num   = hdr_mem[2];
                fr.param_num     = hdr_mem[3];
                fr.type_length   = hdr_mem[4];
                fr.payload_count = 5'(n);
                fr.crc_ok        = (crc_acc == b);
                fr.computed_crc  = crc_acc;
                frames_due.push_back(fr);
                phase = SEEK_START;
            end
        endcase
    endfunction

    function automatic int field_diff(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    function automatic int frame_diff(input frame_result_t want, input frame_result_t got);
        int d;
        d = field_diff("source_addr", want.source_addr, got.source_addr);
        d += field_diff("node_addr", want.node_addr, got.node_addr);
        d += field_diff("channel_num", want.channel_num, got.channel_num);
        d += field_diff("param_num", want.param_num, got.param_num);
        d += field_diff("type_length", want.type_length, got.type_length);
        d += field_diff("payload_count", want.payload_count, got.payload_count);
        d += field_diff("payload_low", want.payload_low, got.payload_low);
        d += field_diff("payload_high", want.payload_high, got.payload_high);
        d += field_diff("crc_ok", want.crc_ok, got.crc_ok);
        d += field_diff("computed_crc", want.computed_crc, got.computed_crc);
        return (d > 0) ? 1 : 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t got;
        if (!rst_n)
        begin
            marker  = tfd_pkg::START_BYTE_RESET;
            phase   = SEEK_START;
            nbytes  = '0;
            crc_acc = '0;
            for (int i = 0; i < 16; i++)
            begin
                body_mem[i] = '0;
            end
            for (int i = 0; i < tfd_pkg::HEADER_BYTES; i++)
            begin
                hdr_mem[i] = '0;
            end
            frames_due.delete();
            errs = 0;
            fail_count <= 0;
            pending    <= 0;
            hunting    <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                marker = cfg_wdata;
            end
            if (in_valid && !in_stall)
            begin
                absorb(rx_byte);
            end
            if (out_valid && !out_stall)
            begin
                got = '{source_addr, node_addr, channel_num, param_num, type_length,
                        payload_count, payload_low, payload_high, crc_ok, computed_crc};
                if (frames_due.size() == 0)
                begin
                    $error("frame result with no frame pending");
                    errs++;
                end
                else
                begin
                    errs += frame_diff(frames_due.pop_front(), got);
                end
            end
            fail_count <= errs;
            pending    <= frames_due.size();
            hunting    <= (phase == SEEK_START);
        end
    end

endmodule

### tb/tb_telemetry_frame_decoder.sv
// Bench top for the telemetry frame decoder: drives serial bytes and back-pressure, gives the verdict.
// Depends on tfd_pkg, the decoder RTL and tfd_checker, which predicts and compares the frames.
`timescale 1ns / 1ps

module tb_telemetry_frame_decoder;

    localparam int MAX_PL       = tfd_pkg::MAX_PAYLOAD_DEF;
    localparam int PHASE_BYTES  = 200;     // random requests per start byte setting
    localparam int PHASES       = 5;
    localparam int CYCLE_LIMIT  = 400000;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  source_addr;
    logic [7:0]  node_addr;
    logic [7:0]  channel_num;
    logic [7:0]  param_num;
    logic [7:0]  type_length;
    logic [4:0]  payload_count;
    logic [63:0] payload_low;
    logic [63:0] payload_high;
    logic        crc_ok;
    logic [7:0]  computed_crc;

    int          fail_count;
    int          pending;
    logic        hunting;

    // Stimulus-side view: the start byte frames are built around, and gap control.
    logic [7:0]  marker;
    bit          no_gaps;
    int          bytes_sent;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    telemetry_frame_decoder #(
        .MAX_PAYLOAD (MAX_PL)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .source_addr   (source_addr),
        .node_addr     (node_addr),
        .channel_num   (channel_num),
        .param_num     (param_num),
        .type_length   (type_length),
        .payload_count (payload_count),
        .payload_low   (payload_low),
        .payload_high  (payload_high),
        .crc_ok        (crc_ok),
        .computed_crc  (computed_crc)
    );

    tfd_checker #(
        .MAX_PAYLOAD (MAX_PL)
    ) i_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .source_addr   (source_addr),
        .node_addr     (node_addr),
        .channel_num   (channel_num),
        .param_num     (param_num),
        .type_length   (type_length),
        .payload_count (payload_count),
        .payload_low   (payload_low),
        .payload_high  (payload_high),
        .crc_ok        (crc_ok),
        .computed_crc  (computed_crc),
        .fail_count    (fail_count),
        .pending       (pending),
        .hunting       (hunting)
    );

    // Downstream back-pressure: free runs, short stalls, now and then a long stall,
    // and occasionally a long stretch with no stall at all.
    initial
    begin
        int r;
        int len;
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                out_stall <= 1'b0;
                len = $urandom_range(100, 300);
            end
            else if (r < 55)
            begin
                out_stall <= 1'b0;
                len = $urandom_range(1, 20);
            end
            else if (r < 92)
            begin
                out_stall <= 1'b1;
                len = $urandom_range(1, 3);
            end
            else
            begin
                out_stall <= 1'b1;
                len = $urandom_range(10, 30);
            end
            repeat (len) @(posedge clk);
        end
    end

    // Watchdog: end the run if the stream never drains.
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Mostly back-to-back requests, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        if (no_gaps)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Any byte except the start marker, for line noise while hunting.
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom);
        end
        while (b == marker);
        return b;
    endfunction

    // Frame content: now and then the start marker itself, which must pass as plain data.
    function automatic logic [7:0] data_byte();
        logic [7:0] b;
        b = 8'($urandom);
        return ($urandom_range(0, 7) == 0) ? marker : b;
    endfunction

    // Offer one request after a random gap and hold it until it is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    // Drop valid for one cycle so the checker's registered status is current.
    task automatic idle_bus();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold off the sender until every predicted frame has come out.
    task automatic wait_drained();
        idle_bus();
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Send start marker, header, payload and CRC byte. A cut at or above zero
    // abandons the frame after that many bytes past the marker.
    task automatic send_frame(input logic [39:0] head, input logic [127:0] body,
                              input bit bad_crc, input int cut);
        logic [7:0] b;
        logic [7:0] crc;
        int         n;
        int         total;
        n = int'(head[35:32]) + 1;
        if (n > MAX_PL)
        begin
            n = MAX_PL;
        end
        total = tfd_pkg::HEADER_BYTES + n;
        crc = 8'h00;
        send_byte(marker);
        for (int i = 0; i < total; i++)
        begin
            if (cut >= 0 && i >= cut)
            begin
                return;
            end
            b = (i < tfd_pkg::HEADER_BYTES) ? head[8*i +: 8]
                                            : body[8*(i - tfd_pkg::HEADER_BYTES) +: 8];
            crc = i_chk.crc_step(crc, b);
            send_byte(b);
        end
        send_byte(bad_crc ? (crc ^ (8'h01 << $urandom_range(0, 7))) : crc);
    endtask

    // Feed filler until the decoder is back to hunting, then let it empty out.
    task automatic settle();
        idle_bus();
        while (!hunting)
        begin
            send_byte(8'($urandom));
            idle_bus();
        end
        wait_drained();
        repeat (3) @(posedge clk);
    endtask

    task automatic write_marker(input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        marker = v;
    endtask

    // One random sequence: mostly well-formed frames, some corrupt, cut short or pure noise.
    task automatic random_sequence();
        logic [39:0]  head;
        logic [127:0] body;
        int           kind;
        int           n;
        if ($urandom_range(0, 19) == 0)
        begin
            no_gaps = !no_gaps;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            wait_drained();
        end
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3)) send_byte(noise_byte());
        end
        for (int i = 0; i < 16; i++)
        begin
            body[8*i +: 8] = data_byte();
        end
        for (int i = 0; i < 4; i++)
        begin
            head[8*i +: 8] = data_byte();
        end
        head[39:32] = 8'($urandom);
        n = int'(head[35:32]) + 1;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            send_frame(head, body, 1'b0, -1);
        end
        else if (kind < 82)
        begin
            send_frame(head, body, 1'b1, -1);
        end
        else if (kind < 92)
        begin
            // Abandoned frame: the next marker is swallowed as frame data.
            send_frame(head, body, 1'b0, $urandom_range(0, tfd_pkg::HEADER_BYTES + n - 1));
        end
        else
        begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end
    endtask

    initial
    begin
        int start_count;
        marker     = tfd_pkg::START_BYTE_RESET;
        no_gaps    = 1'b0;
        bytes_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: noise while hunting, a full 16-byte payload with a bad CRC,
        // then a one-byte payload with a good CRC so the stale upper bytes must read zero.
        send_byte(8'h00);
        send_frame({8'h0F, 8'h00, 8'hFF, 8'h00, 8'hFF},
                   {8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01,
                    marker, 8'h00, 8'hFF, 8'hAA, 8'h55, 8'hFF, 8'h00, 8'hFF},
                   1'b1, -1);
        send_frame({8'hF0, 8'hFF, marker, 8'hFF, 8'h00}, 128'hFF, 1'b0, -1);
        wait_drained();

        // Random phases, each under its own start marker: reset value, both extremes, random.
        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                settle();
                case (p)
                    1: write_marker(8'h00);
                    2: write_marker(8'hFF);
                    default: write_marker(8'($urandom));
                endcase
            end
            start_count = bytes_sent;
            while (bytes_sent - start_count < PHASE_BYTES)
            begin
                random_sequence();
            end
        end

        // Drain and give the output register time to show any stray result.
        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/tfd_pkg.sv
src/telemetry_frame_decoder.sv
src/tfd_checker.sv
tb/tfd_checker.sv
tb/tb_telemetry_frame_decoder.sv
